### rtl/core/lslc_pkg.sv
// Shared types, widths, register indexes and the range gain table of the line calibrator.
package lslc_pkg;

  // Input voltages, signed Q5.16
  localparam int IN_W = 21;
  // Range gain 0.4/range, unsigned Q0.24
  localparam int GAIN_W = 24;
  localparam int GAIN_FRAC = 24;
  // Scaled point, signed Q.16
  localparam int SCL_W = 21;
  // Running sums
  localparam int SX_W = 32;
  localparam int SXY_W = 48;
  // Fit numerator and denominator
  localparam int FIT_W = 50;
  // Q16.16 results
  localparam int FRAC_W = 16;
  localparam int OUT_W = 32;
  localparam int PT_W = 4;
  // Divider
  localparam int DIVISOR_W = 48;
  localparam int DIVIDEND_W = DIVISOR_W + FRAC_W;
  localparam int QUO_W = 31;
  // Configuration port
  localparam int RANGE_W = 3;
  localparam int COUNT_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 2'd1;

  // Gain per range code, codes past the last range use the widest range
  localparam logic [GAIN_W-1:0] GAIN_Q24 [8] = '{
    24'd11184811, 24'd3355443, 24'd1677722, 24'd838861,
    24'd479349, 24'd479349, 24'd479349, 24'd479349
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_MULT,
    ST_ACCUM,
    ST_CHECK,
    ST_FIT_SUB,
    ST_DEN_CHECK,
    ST_SLOPE_WAIT,
    ST_ICPT_MUL,
    ST_ICPT_SUB,
    ST_ICPT_DIV,
    ST_ICPT_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SCALE,
    OP_ROUND,
    OP_MULT,
    OP_ACCUM,
    OP_FIT_MUL,
    OP_FIT_SUB,
    OP_SLOPE_DIV,
    OP_SLOPE_END,
    OP_ICPT_MUL,
    OP_ICPT_SUB,
    OP_ICPT_DIV,
    OP_ICPT_END,
    OP_EMIT_POINT,
    OP_EMIT_DEGEN,
    OP_EMIT_FIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   clear;
  } dp_cmd_t;

  typedef struct packed {
    logic last_point;
    logic den_zero;
    logic div_done;
  } dp_status_t;

endpackage

### rtl/core/lslc_div.sv
// Restoring divider: one quotient bit per cycle, with overflow and round-half-up flags.
module lslc_div
  import lslc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quotient_o,
  output logic                  overflow_o,
  output logic                  round_up_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]     shift_q, shift_d;
  logic [DIVISOR_W-1:0] dvs_q;
  logic                 ovf_q;
  logic [DIVISOR_W:0]   trial;
  logic                 trial_ge;
  logic [DIVIDEND_W-QUO_W-1:0] head;

  assign head = dividend_i[DIVIDEND_W-1:QUO_W];

  // One restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial    = {rem_q, shift_q[QUO_W-1]};
    trial_ge = trial >= {1'b0, dvs_q};
    rem_d    = trial_ge ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
    shift_d  = {shift_q[QUO_W-2:0], trial_ge};
    cnt_d    = cnt_q - CNT_W'(1);
    done_d   = (cnt_q == CNT_W'(1));
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(QUO_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder, dividend bits and quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= DIVISOR_W'(head);
      shift_q <= dividend_i[QUO_W-1:0];
      dvs_q   <= divisor_i;
      ovf_q   <= DIVISOR_W'(head) >= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q   <= rem_d;
      shift_q <= shift_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;
  assign overflow_o = ovf_q;
  assign round_up_o = {rem_q, 1'b0} >= {1'b0, dvs_q};

endmodule

### rtl/core/lslc_datapath.sv
// Datapath: point scaling, running sums, fit terms, shared divider and result registers.
module lslc_datapath
  import lslc_pkg::*;
#(
  parameter int MAX_POINTS = 8,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic signed [IN_W-1:0]  drive_voltage_i,
  input  logic signed [IN_W-1:0]  received_voltage_i,
  input  logic [RANGE_W-1:0]      gain_sel_i,
  input  logic [CNT_W-1:0]        fit_len_i,
  output logic                    result_valid_o,
  output logic [PT_W-1:0]         points_taken_o,
  output logic                    fit_done_o,
  output logic signed [OUT_W-1:0] slope_out_o,
  output logic signed [OUT_W-1:0] intercept_out_o,
  output logic                    degenerate_o
);

  localparam int PROD_W = IN_W + GAIN_W;
  localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (GAIN_FRAC - 1);

  function automatic logic signed [OUT_W-1:0] sat_q16(input logic neg, input logic ovf,
                                                      input logic [OUT_W-1:0] mag);
    logic signed [OUT_W-1:0] res;
    if (ovf) begin
      res = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else if (neg) begin
      res = mag[OUT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : -$signed(mag);
    end else begin
      res = mag[OUT_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : $signed(mag);
    end
    return res;
  endfunction

  // Scaling stage
  logic [IN_W-1:0]   x_mag, y_mag;
  logic [PROD_W-1:0] x_prod_d, y_prod_d, x_prod_q, y_prod_q;
  logic              x_neg_q, y_neg_q;
  logic [PROD_W:0]   x_rnd, y_rnd;
  logic [SCL_W-1:0]  x_sc, y_sc;
  logic signed [SCL_W-1:0] x_d, y_d, x_q, y_q;
  logic signed [2*SCL_W-1:0] xy_d, xx_d, xy_q, xx_q;

  // Running sums
  logic signed [SX_W-1:0]  sum_x_q, sum_y_q;
  logic signed [SXY_W-1:0] sum_xy_q, sum_xx_q;
  logic [CNT_W-1:0]        points_q;

  // Fit terms
  logic signed [CNT_W:0]        n_s;
  logic signed [CNT_W+SXY_W:0]  nsxy, nsxx;
  logic signed [2*SX_W-1:0]     sxsy, sxsx;
  logic signed [FIT_W-1:0]      a_q, b_q, c_q, e_q, num_q, den_q;
  logic [FIT_W-1:0]             num_mag;
  logic signed [OUT_W-1:0]      slope_q, icpt_q;
  logic signed [OUT_W+SX_W-1:0] sp_d, sp_q;
  logic signed [DIVIDEND_W-1:0] diff_d, diff_q;
  logic [DIVIDEND_W-1:0]        diff_mag;

  // Divider interface
  logic                  div_start, div_done, div_ovf, div_rnd, div_neg_q;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [QUO_W-1:0]      div_quo;
  logic [OUT_W-1:0]      q_mag;
  logic signed [OUT_W-1:0] q_sat;

  // Result registers
  logic                    valid_q;
  logic [PT_W-1:0]         out_points_q;
  logic                    out_done_q, out_degen_q;
  logic signed [OUT_W-1:0] out_slope_q, out_icpt_q;

  // Magnitudes and gain products of the incoming point
  assign x_mag    = drive_voltage_i[IN_W-1] ? (~drive_voltage_i + 1'b1) : drive_voltage_i;
  assign y_mag    = received_voltage_i[IN_W-1] ? (~received_voltage_i + 1'b1)
                                                : received_voltage_i;
  assign x_prod_d = x_mag * GAIN_Q24[gain_sel_i];
  assign y_prod_d = y_mag * GAIN_Q24[gain_sel_i];

  // Round to nearest, ties away from zero, then restore the sign
  assign x_rnd = {1'b0, x_prod_q} + RND_HALF;
  assign y_rnd = {1'b0, y_prod_q} + RND_HALF;
  assign x_sc  = x_rnd[GAIN_FRAC +: SCL_W];
  assign y_sc  = y_rnd[GAIN_FRAC +: SCL_W];
  assign x_d   = x_neg_q ? -$signed(x_sc) : $signed(x_sc);
  assign y_d   = y_neg_q ? -$signed(y_sc) : $signed(y_sc);
  assign xy_d  = x_q * y_q;
  assign xx_d  = x_q * x_q;

  // Fit products
  assign n_s  = {1'b0, fit_len_i};
  assign nsxy = n_s * sum_xy_q;
  assign nsxx = n_s * sum_xx_q;
  assign sxsy = sum_x_q * sum_y_q;
  assign sxsx = sum_x_q * sum_x_q;

  // Intercept terms
  assign sp_d     = slope_q * sum_x_q;
  assign diff_d   = (DIVIDEND_W'(sum_y_q) <<< FRAC_W) - DIVIDEND_W'(sp_q);
  assign num_mag  = num_q[FIT_W-1] ? FIT_W'(-num_q) : FIT_W'(num_q);
  assign diff_mag = diff_q[DIVIDEND_W-1] ? DIVIDEND_W'(-diff_q) : DIVIDEND_W'(diff_q);

  // Steer the shared divider
  always_comb begin
    div_start = (cmd_i.op == OP_SLOPE_DIV) || (cmd_i.op == OP_ICPT_DIV);
    if (cmd_i.op == OP_SLOPE_DIV) begin
      div_dividend = {num_mag[DIVISOR_W-1:0], {FRAC_W{1'b0}}};
      div_divisor  = den_q[DIVISOR_W-1:0];
    end else begin
      div_dividend = diff_mag;
      div_divisor  = DIVISOR_W'({fit_len_i, {FRAC_W{1'b0}}});
    end
  end

  lslc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .overflow_o (div_ovf),
    .round_up_o (div_rnd)
  );

  assign q_mag = {1'b0, div_quo} + OUT_W'(div_rnd);
  assign q_sat = sat_q16(div_neg_q, div_ovf, q_mag);

  // Sums and point count: accumulate, or drop on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
      points_q <= '0;
    end else if (cmd_i.clear) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
      points_q <= '0;
    end else if (cmd_i.op == OP_ACCUM) begin
      sum_x_q  <= sum_x_q + SX_W'(x_q);
      sum_y_q  <= sum_y_q + SX_W'(y_q);
      sum_xy_q <= sum_xy_q + SXY_W'(xy_q);
      sum_xx_q <= sum_xx_q + SXY_W'(xx_q);
      points_q <= points_q + CNT_W'(1);
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.op == OP_EMIT_POINT) || (cmd_i.op == OP_EMIT_DEGEN) ||
                 (cmd_i.op == OP_EMIT_FIT);
    end
  end

  // Pipeline and result payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_SCALE: begin
        x_prod_q <= x_prod_d;
        y_prod_q <= y_prod_d;
        x_neg_q  <= drive_voltage_i[IN_W-1];
        y_neg_q  <= received_voltage_i[IN_W-1];
      end
      OP_ROUND: begin
        x_q <= x_d;
        y_q <= y_d;
      end
      OP_MULT: begin
        xy_q <= xy_d;
        xx_q <= xx_d;
      end
      OP_ACCUM: begin
      end
      OP_FIT_MUL: begin
        a_q <= FIT_W'(nsxy);
        b_q <= FIT_W'(sxsy);
        c_q <= FIT_W'(nsxx);
        e_q <= FIT_W'(sxsx);
      end
      OP_FIT_SUB: begin
        num_q <= a_q - b_q;
        den_q <= c_q - e_q;
      end
      OP_SLOPE_DIV: begin
        div_neg_q <= num_q[FIT_W-1];
      end
      OP_SLOPE_END: begin
        slope_q <= q_sat;
      end
      OP_ICPT_MUL: begin
        sp_q <= sp_d;
      end
      OP_ICPT_SUB: begin
        diff_q <= diff_d;
      end
      OP_ICPT_DIV: begin
        div_neg_q <= diff_q[DIVIDEND_W-1];
      end
      OP_ICPT_END: begin
        icpt_q <= q_sat;
      end
      OP_EMIT_POINT: begin
        out_points_q <= PT_W'(points_q);
        out_done_q   <= 1'b0;
        out_degen_q  <= 1'b0;
        out_slope_q  <= '0;
        out_icpt_q   <= '0;
      end
      OP_EMIT_DEGEN: begin
        out_points_q <= PT_W'(points_q);
        out_done_q   <= 1'b1;
        out_degen_q  <= 1'b1;
        out_slope_q  <= '0;
        out_icpt_q   <= '0;
      end
      OP_EMIT_FIT: begin
        out_points_q <= PT_W'(points_q);
        out_done_q   <= 1'b1;
        out_degen_q  <= 1'b0;
        out_slope_q  <= slope_q;
        out_icpt_q   <= icpt_q;
      end
    endcase
  end

  assign status_o.last_point = points_q >= fit_len_i;
  assign status_o.den_zero   = den_q[FIT_W-1] || (den_q == '0);
  assign status_o.div_done   = div_done;

  assign result_valid_o  = valid_q;
  assign points_taken_o  = out_points_q;
  assign fit_done_o      = out_done_q;
  assign slope_out_o     = out_slope_q;
  assign intercept_out_o = out_icpt_q;
  assign degenerate_o    = out_degen_q;

endmodule

### rtl/core/lslc_ctrl.sv
// Controller: sequences scaling, accumulation and the two-division fit over the datapath.
module lslc_ctrl
  import lslc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       clear_req_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    cmd_o.clear = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        priority if (start_i) begin
          cmd_o.op = OP_SCALE;
          state_d  = ST_ROUND;
        end else if (clear_req_i) begin
          cmd_o.clear = 1'b1;
        end
      end
      ST_ROUND: begin
        cmd_o.op = OP_ROUND;
        state_d  = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.op = OP_MULT;
        state_d  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.op = OP_ACCUM;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.last_point) begin
          cmd_o.op = OP_FIT_MUL;
          state_d  = ST_FIT_SUB;
        end else begin
          cmd_o.op = OP_EMIT_POINT;
          state_d  = ST_IDLE;
        end
      end
      ST_FIT_SUB: begin
        cmd_o.op = OP_FIT_SUB;
        state_d  = ST_DEN_CHECK;
      end
      ST_DEN_CHECK: begin
        if (status_i.den_zero) begin
          cmd_o.op    = OP_EMIT_DEGEN;
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.op = OP_SLOPE_DIV;
          state_d  = ST_SLOPE_WAIT;
        end
      end
      ST_SLOPE_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_SLOPE_END;
          state_d  = ST_ICPT_MUL;
        end
      end
      ST_ICPT_MUL: begin
        cmd_o.op = OP_ICPT_MUL;
        state_d  = ST_ICPT_SUB;
      end
      ST_ICPT_SUB: begin
        cmd_o.op = OP_ICPT_SUB;
        state_d  = ST_ICPT_DIV;
      end
      ST_ICPT_DIV: begin
        cmd_o.op = OP_ICPT_DIV;
        state_d  = ST_ICPT_WAIT;
      end
      ST_ICPT_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_ICPT_END;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.op    = OP_EMIT_FIT;
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### rtl/core/least_squares_line_calibrator.sv
// Top level of the least-squares line calibrator: configuration, range table, control and datapath.
//
// Usage: a calibration point (drive_voltage_i, received_voltage_i, signed Q5.16 volts)
// transfers at a rising edge with start high and busy low. Each point yields one result:
// result_valid_o is high for exactly one cycle with points_taken_o, fit_done_o,
// slope_out_o, intercept_out_o and degenerate_o; the receiver cannot stall it.
// A point that does not close the fit, a closing point that meets a zero denominator and
// a closing point with a real fit take successively longer; the last runs the shared
// restoring divider for 31 one-bit steps for the slope and again for the intercept.
// One point is in flight at a time; busy is low again in the result cycle, so the next
// point may transfer at the edge that ends it.
// Configuration writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) transfer while
// the block is idle and no point is offered; index 0 is range_select, index 1 is
// point_count. A write to either restarts the fit; other indexes are ignored. Each
// finished fit stores slope and intercept for the selected range.
// Reset: asynchronous, active low. Sums and the point count clear, range_select returns
// to 0, point_count to 1, and the stored range table to zero. No clearing pass is needed.
module least_squares_line_calibrator
  import lslc_pkg::*;
#(
  parameter int MAX_POINTS  = 8,
  parameter int RANGE_COUNT = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  drive_voltage_i,
  input  logic signed [IN_W-1:0]  received_voltage_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic                    result_valid_o,
  output logic [PT_W-1:0]         points_taken_o,
  output logic                    fit_done_o,
  output logic signed [OUT_W-1:0] slope_out_o,
  output logic signed [OUT_W-1:0] intercept_out_o,
  output logic                    degenerate_o
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int RIDX_W = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;

  logic [RANGE_W-1:0] range_q;
  logic [COUNT_W-1:0] count_q;
  logic               cfg_xfer, cfg_clear;
  logic [RANGE_W-1:0] gain_sel;
  logic [RIDX_W-1:0]  rsel;
  logic [CNT_W-1:0]   fit_len;
  logic               busy_int;
  dp_cmd_t            cmd;
  dp_status_t         status;

  logic signed [OUT_W-1:0] cal_slope_q [RANGE_COUNT];
  logic signed [OUT_W-1:0] cal_icpt_q  [RANGE_COUNT];

  // Configuration transfers only while idle and no point is offered
  assign cfg_ready_o = !busy_int && !start;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_xfer &&
                       ((cfg_index_i == REG_RANGE_SELECT) || (cfg_index_i == REG_POINT_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= '0;
      count_q <= COUNT_W'(1);
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        REG_RANGE_SELECT: range_q <= cfg_data_i[RANGE_W-1:0];
        REG_POINT_COUNT:  count_q <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the range code and the fit length
  always_comb begin
    gain_sel = (32'(range_q) >= RANGE_COUNT) ? RANGE_W'(RANGE_COUNT - 1) : range_q;
    rsel     = gain_sel[RIDX_W-1:0];
    if (count_q == '0) begin
      fit_len = CNT_W'(1);
    end else if (32'(count_q) > MAX_POINTS) begin
      fit_len = CNT_W'(MAX_POINTS);
    end else begin
      fit_len = CNT_W'(count_q);
    end
  end

  lslc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .clear_req_i (cfg_clear),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_int)
  );

  lslc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .drive_voltage_i    (drive_voltage_i),
    .received_voltage_i (received_voltage_i),
    .gain_sel_i         (gain_sel),
    .fit_len_i          (fit_len),
    .result_valid_o     (result_valid_o),
    .points_taken_o     (points_taken_o),
    .fit_done_o         (fit_done_o),
    .slope_out_o        (slope_out_o),
    .intercept_out_o    (intercept_out_o),
    .degenerate_o       (degenerate_o)
  );

  // Store each finished fit in the slot of the selected range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RANGE_COUNT; i++) begin
        cal_slope_q[i] <= '0;
        cal_icpt_q[i]  <= '0;
      end
    end else if (result_valid_o && fit_done_o) begin
      cal_slope_q[rsel] <= slope_out_o;
      cal_icpt_q[rsel]  <= intercept_out_o;
    end
  end

  assign busy = busy_int;

  // Accepted point makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("point transfer did not start processing");

  // A degenerate fit reports zero slope and intercept
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && degenerate_o |-> fit_done_o && slope_out_o == '0 &&
      intercept_out_o == '0)
    else $error("degenerate fit with nonzero coefficients");

  // A finished fit counts exactly the configured number of points
  a_fit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && fit_done_o |-> points_taken_o == PT_W'(fit_len))
    else $error("fit closed at the wrong point count");

  // The range table holds the pair just delivered
  a_table_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && fit_done_o |=>
      cal_slope_q[$past(rsel)] == $past(slope_out_o) &&
      cal_icpt_q[$past(rsel)] == $past(intercept_out_o))
    else $error("range table not updated with the finished fit");

endmodule

### sim/tb_least_squares_line_calibrator.sv
// Testbench for the least-squares line calibrator: predicted fits are checked against every result.
`timescale 1ns / 100ps

// Running fit state of the calibrator plus the queue of results it still owes
class line_fit_tracker;
  localparam int RANGE_SLOTS = 5;
  localparam int MAX_FIT = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0]  taken;
    logic        done;
    logic [31:0] slope;
    logic [31:0] icpt;
    logic        degen;
  } fit_result_t;

  bit [2:0]    range_sel;
  bit [3:0]    pt_count;
  longint      sum_x;
  longint      sum_y;
  longint      sum_xy;
  longint      sum_xx;
  int unsigned points_seen;
  fit_result_t pending_fits[$];
  int unsigned mismatches;

  function new();
    range_sel = '0;
    pt_count = 4'd1;
    mismatches = 0;
    clear_sums();
  endfunction

  function void clear_sums();
    sum_x = 0;
    sum_y = 0;
    sum_xy = 0;
    sum_xx = 0;
    points_seen = 0;
  endfunction

  // Mirror a configuration transfer; listed registers restart the fit
  function void apply_config(bit [1:0] idx, bit [3:0] val);
    if (idx == lslc_pkg::REG_RANGE_SELECT) begin
      range_sel = val[2:0];
      clear_sums();
    end else if (idx == lslc_pkg::REG_POINT_COUNT) begin
      pt_count = val;
      clear_sums();
    end
  endfunction

  function int unsigned fit_len();
    if (pt_count == 0) return 1;
    if (pt_count > MAX_FIT) return MAX_FIT;
    return pt_count;
  endfunction

  function int unsigned range_slot();
    return (range_sel >= RANGE_SLOTS) ? RANGE_SLOTS - 1 : range_sel;
  endfunction

  // Scale by the range gain, rounding half away from zero
  function longint scale_volt(longint v, longint unsigned gain);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * gain + (64'd1 << 23)) >> 24;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function longint clamp_q16(bit neg, longint unsigned mag);
    if (neg) begin
      if (mag >= 64'h8000_0000) return -64'sd2147483648;
      return -longint'(mag);
    end
    if (mag > 64'h7FFF_FFFF) return 64'sd2147483647;
    return longint'(mag);
  endfunction

  // Q16.16 quotient of num/den, rounded half away from zero, saturated
  function longint slope_q16(longint num, longint unsigned den);
    bit               neg;
    longint unsigned  mag;
    longint unsigned  q;
    longint unsigned  r;
    longint unsigned  f;
    longint unsigned  fr;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    if (q >= 64'h8000) return clamp_q16(neg, 64'hFFFF_FFFF);
    f = r << 16;
    fr = f % den;
    f = f / den;
    if (2 * fr >= den) f++;
    return clamp_q16(neg, (q << 16) + f);
  endfunction

  // Accumulate one accepted point and queue the result it must produce
  function void take_point(logic signed [20:0] dv, logic signed [20:0] rv);
    longint unsigned gain;
    longint          x;
    longint          y;
    longint          n;
    longint          num;
    longint          den;
    longint          diff;
    longint          slope;
    longint          icpt;
    longint unsigned mag;
    longint unsigned div;
    longint unsigned q;
    longint unsigned rm;
    fit_result_t     res;
    gain = lslc_pkg::GAIN_Q24[range_slot()];
    x = scale_volt(longint'(dv), gain);
    y = scale_volt(longint'(rv), gain);
    sum_x += x;
    sum_y += y;
    sum_xy += x * y;
    sum_xx += x * x;
    points_seen++;
    n = fit_len();
    slope = 0;
    icpt = 0;
    res = '0;
    res.taken = points_seen[3:0];
    if (points_seen >= n) begin
      res.done = 1'b1;
      num = n * sum_xy - sum_x * sum_y;
      den = n * sum_xx - sum_x * sum_x;
      if (den <= 0) begin
        res.degen = 1'b1;
      end else begin
        slope = slope_q16(num, den);
        // Intercept uses the saturated slope
        diff = sum_y * 65536 - slope * sum_x;
        mag = (diff < 0) ? -diff : diff;
        div = n << 16;
        q = mag / div;
        rm = mag % div;
        if (2 * rm >= div) q++;
        icpt = clamp_q16(diff < 0, q);
      end
      clear_sums();
    end
    res.slope = slope[31:0];
    res.icpt = icpt[31:0];
    pending_fits.push_back(res);
  endfunction

  function void flag(string what, fit_result_t want, fit_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: expected taken=%0d done=%0d slope=%h icpt=%h degen=%0d, got taken=%0d done=%0d slope=%h icpt=%h degen=%0d",
               $time, what, want.taken, want.done, want.slope, want.icpt, want.degen,
               got.taken, got.done, got.slope, got.icpt, got.degen);
  endfunction

  // Compare one result transfer with the oldest queued result
  function void check_result(logic [3:0] taken, logic done, logic [31:0] slope,
                             logic [31:0] icpt, logic degen);
    fit_result_t got;
    fit_result_t want;
    got = '{taken, done, slope, icpt, degen};
    if (pending_fits.size() == 0) begin
      flag("result with nothing outstanding", got, got);
      return;
    end
    want = pending_fits.pop_front();
    if (got.taken !== want.taken || got.done !== want.done || got.slope !== want.slope ||
        got.icpt !== want.icpt || got.degen !== want.degen)
      flag("result mismatch", want, got);
  endfunction

  function int unsigned pending();
    return pending_fits.size();
  endfunction

  function bit all_clear();
    if (pending_fits.size() != 0) begin
      flag("results never delivered", pending_fits[0], pending_fits[0]);
      mismatches += pending_fits.size() - 1;
    end
    return mismatches == 0;
  endfunction
endclass

module tb_least_squares_line_calibrator;
  import lslc_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 6;
  localparam int ITEM_TARGET = 1550;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [IN_W-1:0] V_MAX = 21'sd983040;
  localparam logic signed [IN_W-1:0] V_MIN = -21'sd983040;
  localparam logic signed [IN_W-1:0] CODE_MAX = 21'sd1048575;
  localparam logic signed [IN_W-1:0] CODE_MIN = -21'sd1048576;

  typedef enum int {
    MODE_NOISE,
    MODE_LINE,
    MODE_SAME_X,
    MODE_TIGHT_X
  } point_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [IN_W-1:0]  drive_voltage_i = '0;
  logic signed [IN_W-1:0]  received_voltage_i = '0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    result_valid_o;
  logic [PT_W-1:0]         points_taken_o;
  logic                    fit_done_o;
  logic signed [OUT_W-1:0] slope_out_o;
  logic signed [OUT_W-1:0] intercept_out_o;
  logic                    degenerate_o;

  line_fit_tracker fit_tracker = new();
  int unsigned     points_sent = 0;
  int unsigned     stall_cycles = 0;
  bit              no_idle = 1'b0;

  least_squares_line_calibrator u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .drive_voltage_i    (drive_voltage_i),
    .received_voltage_i (received_voltage_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .points_taken_o     (points_taken_o),
    .fit_done_o         (fit_done_o),
    .slope_out_o        (slope_out_o),
    .intercept_out_o    (intercept_out_o),
    .degenerate_o       (degenerate_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      fit_tracker.check_result(points_taken_o, fit_done_o, slope_out_o, intercept_out_o,
                               degenerate_o);
  end

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [IN_W-1:0] clip(longint v);
    if (v > V_MAX) return V_MAX;
    if (v < V_MIN) return V_MIN;
    return v[IN_W-1:0];
  endfunction

  function automatic logic signed [IN_W-1:0] in_span();
    return int'($urandom_range(0, 1966080)) - 983040;
  endfunction

  // Mostly in-span voltages, some raw codes beyond +-15 V and some extremes
  function automatic logic signed [IN_W-1:0] any_volt();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: return CODE_MAX;
          1: return CODE_MIN;
          2: return V_MAX;
          3: return V_MIN;
          4: return 1;
          default: return -1;
        endcase
      end
      default: return in_span();
    endcase
  endfunction

  // Drop start and hold until every queued result has come back
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (fit_tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_point(input logic signed [IN_W-1:0] dv, input logic signed [IN_W-1:0] rv);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    drive_voltage_i <= dv;
    received_voltage_i <= rv;
    do @(posedge clk_i); while (busy);
    fit_tracker.take_point(dv, rv);
    points_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int unsigned gap;
    wait_idle();
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    fit_tracker.apply_config(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send npts points shaped by mode
  task automatic run_fit(input point_mode_e mode, input int unsigned npts);
    int                     slope_a;
    int                     offset_b;
    logic signed [IN_W-1:0] x_base;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    slope_a = int'($urandom_range(0, 262144)) - 131072;
    offset_b = int'($urandom_range(0, 400000)) - 200000;
    x_base = any_volt();
    for (int unsigned i = 0; i < npts; i++) begin
      case (mode)
        MODE_LINE: begin
          x = in_span();
          y = clip(((longint'(x) * slope_a) >>> 16) + offset_b +
                   longint'($urandom_range(0, 128)) - 64);
        end
        MODE_SAME_X: begin
          x = x_base;
          y = any_volt();
        end
        MODE_TIGHT_X: begin
          x = clip(longint'(x_base) + longint'($urandom_range(0, 3)));
          y = any_volt();
        end
        default: begin
          x = any_volt();
          y = any_volt();
        end
      endcase
      send_point(x, y);
    end
  endtask

  function automatic point_mode_e pick_mode();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return MODE_LINE;
    if (roll < 7) return MODE_NOISE;
    if (roll < 8) return MODE_SAME_X;
    return MODE_TIGHT_X;
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // One-point fits at reset settings, full code extremes
    send_point(CODE_MAX, CODE_MIN);
    send_point(CODE_MIN, CODE_MAX);

    // Unit slopes on the widest range
    write_reg(REG_POINT_COUNT, 4'd2);
    write_reg(REG_RANGE_SELECT, 4'd4);
    send_point(V_MAX, V_MAX);
    send_point(V_MIN, V_MIN);
    send_point(V_MIN, V_MAX);
    send_point(V_MAX, V_MIN);

    // Near-vertical lines saturate the slope both ways
    write_reg(REG_RANGE_SELECT, 4'd0);
    send_point(0, V_MIN);
    send_point(1, V_MAX);
    send_point(0, V_MAX);
    send_point(1, V_MIN);

    // Oversized count and range codes clamp; equal x gives a zero denominator
    write_reg(REG_POINT_COUNT, 4'd15);
    write_reg(REG_RANGE_SELECT, 4'd7);
    for (int i = 0; i < 8; i++) send_point(21'sd12345, 100000 * i - 400000);

    // Listed write mid-fit restarts, spare index leaves the fit alone
    write_reg(REG_POINT_COUNT, 4'd3);
    write_reg(REG_RANGE_SELECT, 4'd2);
    send_point(-21'sd300000, 21'sd5000);
    write_reg(REG_RANGE_SELECT, 4'd1);
    send_point(-21'sd500000, -21'sd250000);
    write_reg(REG_SPARE_B, 4'd9);
    send_point(21'sd100000, 21'sd50000);
    send_point(21'sd700000, 21'sd350000);

    // Zero count acts as one
    write_reg(REG_POINT_COUNT, 4'd0);
    send_point(21'sd500000, -21'sd500000);

    // Random phases: new settings, then whole fits, sometimes a trailing partial fit
    while (points_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_RANGE_SELECT, $urandom_range(0, 15));
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_POINT_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) :
                                                                  $urandom_range(1, 8));
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(0, 15));
      repeat ($urandom_range(1, 4)) run_fit(pick_mode(), fit_tracker.fit_len());
      if ($urandom_range(0, 4) == 0)
        run_fit(pick_mode(), $urandom_range(1, fit_tracker.fit_len()));
      wait_idle();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fit_tracker.all_clear())
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
